FILE: rtl/sle_pkg.sv
// Package for the serial line editor: item types, command codes and character constants.
package sle_pkg;

	localparam int LINE_LEN_DEF   = 20;
	localparam int RING_DEPTH_DEF = 256;

	// Depth of the front-to-back command queue.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = 1;

	// Item operation codes
	localparam logic [1:0] OP_RX_BYTE  = 2'd0;
	localparam logic [1:0] OP_TX_READY = 2'd1;
	localparam logic [1:0] OP_HOST_WR  = 2'd2;
	localparam logic [1:0] OP_LINE_RD  = 2'd3;

	// Back-end command kinds
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_PUSH = 2'd1;
	localparam logic [1:0] CMD_POP  = 2'd2;

	localparam logic [7:0] CH_MASK7 = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic [4:0] line_index;
		logic       clear_ready;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       line_ready;
		logic [7:0] line_char;
		logic       ring_full;
	} out_item_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [1:0]      kind;
		logic [1:0]      nbytes;
		logic [2:0][7:0] bytes;
		logic            line_ready;
		logic [7:0]      line_char;
	} cmd_t;

endpackage

FILE: rtl/sle_front.sv
// Front end: accepts requests, edits the line store and classifies ring work.
module sle_front #(
	parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sle_pkg::in_item_t item,
	output logic             q_wvalid,
	input  logic             q_wready,
	output sle_pkg::cmd_t    q_wdata
);
	import sle_pkg::*;

	localparam int LW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

	logic [LW-1:0]   fill_q;
	logic            ready_q;
	logic [LINE_LEN-1:0] lvalid_q;
	logic [7:0]      line_mem [LINE_LEN];

	logic            v_s1;
	cmd_t            cmd_s1;
	logic            rdok_s1;
	logic [7:0]      rd_s1;

	logic            acc;
	logic [7:0]      ch;
	logic [7:0]      ch_store;
	logic            is_rx;
	logic            is_cr;
	logic            is_bs;
	logic            is_pr;
	logic            can_store;
	logic            wr_en;
	logic [7:0]      wr_data;
	logic [31:0]     idx_ext;
	logic            idx_ok;
	logic [LW-1:0]   rd_addr;
	cmd_t            cmd_new;

	assign item_ready = !v_s1 || q_wready;
	assign acc        = item_valid && item_ready;

	assign ch        = item.data_byte & CH_MASK7;
	assign ch_store  = ch | CH_SPACE;
	assign is_rx     = (item.op == OP_RX_BYTE);
	assign is_cr     = is_rx && (ch == CH_CR);
	assign is_bs     = is_rx && (ch == CH_BS) && (fill_q != '0);
	assign is_pr     = is_rx && (ch >= CH_SPACE);
	assign can_store = (32'(fill_q) < 32'(LINE_LEN - 1));

	assign wr_en   = is_cr || (is_pr && can_store);
	assign wr_data = is_cr ? CH_NUL : ch_store;

	assign idx_ext = 32'(item.line_index);
	assign idx_ok  = (idx_ext < 32'(LINE_LEN));
	assign rd_addr = idx_ext[LW-1:0];

	always_comb begin
		cmd_new            = '0;
		cmd_new.kind       = CMD_NONE;
		cmd_new.line_ready = is_cr ? 1'b1 : ready_q;
		if (is_cr) begin
			cmd_new.kind   = CMD_PUSH;
			cmd_new.nbytes = 2'd2;
			cmd_new.bytes  = {CH_NUL, CH_LF, CH_CR};
		end else if (is_bs) begin
			cmd_new.kind   = CMD_PUSH;
			cmd_new.nbytes = 2'd3;
			cmd_new.bytes  = {CH_BS, CH_SPACE, CH_BS};
		end else if (is_pr && can_store) begin
			cmd_new.kind   = CMD_PUSH;
			cmd_new.nbytes = 2'd1;
			cmd_new.bytes  = {CH_NUL, CH_NUL, ch_store};
		end else begin
			case (item.op)
				OP_TX_READY: begin
					cmd_new.kind = CMD_POP;
				end
				OP_HOST_WR: begin
					cmd_new.kind   = CMD_PUSH;
					cmd_new.nbytes = 2'd1;
					cmd_new.bytes  = {CH_NUL, CH_NUL, item.data_byte};
				end
				default: begin
					cmd_new.kind = CMD_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ready_q  <= 1'b0;
			lvalid_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (q_wready) begin
				v_s1 <= 1'b0;
			end
			if (acc) begin
				if (wr_en) begin
					lvalid_q[fill_q] <= 1'b1;
				end
				if (is_cr) begin
					fill_q  <= '0;
					ready_q <= 1'b1;
				end else if (is_bs) begin
					fill_q <= fill_q - LW'(1);
				end else if (is_pr && can_store) begin
					fill_q <= fill_q + LW'(1);
				end else if (item.op == OP_LINE_RD && item.clear_ready) begin
					ready_q <= 1'b0;
				end
			end
		end
	end

	// Payload stage and line store; entries never written read as zero via lvalid_q
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= cmd_new;
			rdok_s1 <= (item.op == OP_LINE_RD) && idx_ok && lvalid_q[rd_addr];
			rd_s1   <= line_mem[rd_addr];
			if (wr_en) begin
				line_mem[fill_q] <= wr_data;
			end
		end
	end

	always_comb begin
		q_wdata           = cmd_s1;
		q_wdata.line_char = rdok_s1 ? rd_s1 : CH_NUL;
	end

	assign q_wvalid = v_s1;

endmodule

FILE: rtl/sle_queue.sv
// Short command queue between front and back ends.
module sle_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wvalid,
	output logic          wready,
	input  sle_pkg::cmd_t wdata,
	output logic          rvalid,
	input  logic          rready,
	output sle_pkg::cmd_t rdata
);
	import sle_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wp_q;
	logic [QUEUE_PW-1:0] rp_q;
	logic [CW-1:0]       cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign wready = (cnt_q != CW'(QUEUE_DEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata  = slot_q[rp_q];
	assign do_wr  = wvalid && wready;
	assign do_rd  = rvalid && rready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + QUEUE_PW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + QUEUE_PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

FILE: rtl/sle_back.sv
// Back end: transmit ring, echo pushes, pops and the result register.
module sle_back #(
	parameter int RING_DEPTH = sle_pkg::RING_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_rvalid,
	output logic              q_rready,
	input  sle_pkg::cmd_t     q_rdata,
	output logic              result_valid,
	input  logic              result_ready,
	output sle_pkg::out_item_t result
);
	import sle_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);

	logic [7:0]    ring_mem [RING_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic          full_q;
	logic [1:0]    bcnt_q;
	logic [7:0]    rd_q;
	logic          res_v_q;
	out_item_t     res_q;

	logic          out_free;
	logic          go;
	logic          is_push;
	logic          is_pop;
	logic          last;
	logic          nonempty;
	logic [PW-1:0] wp_nxt;
	logic [PW-1:0] rp_nxt;
	logic          wr_en;
	logic          rd_en;
	logic          full_after_push;
	logic [7:0]    wbyte;
	out_item_t     res_new;

	assign out_free = !res_v_q || result_ready;
	assign go       = q_rvalid && out_free;
	assign is_push  = (q_rdata.kind == CMD_PUSH);
	assign is_pop   = (q_rdata.kind == CMD_POP);
	assign last     = (bcnt_q == q_rdata.nbytes - 2'd1);
	assign nonempty = (wp_q != rp_q) || full_q;
	assign wp_nxt   = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + PW'(1);
	assign rp_nxt   = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : rp_q + PW'(1);
	assign wbyte    = q_rdata.bytes[bcnt_q];

	// a push into a full ring is dropped
	assign wr_en           = go && is_push && !full_q;
	assign rd_en           = go && is_pop && nonempty;
	assign full_after_push = full_q || (wp_nxt == rp_q);

	assign q_rready = go && (!is_push || last);

	always_comb begin
		res_new            = '0;
		res_new.line_ready = q_rdata.line_ready;
		res_new.line_char  = q_rdata.line_char;
		res_new.tx_valid   = is_pop && nonempty;
		case (q_rdata.kind)
			CMD_PUSH: res_new.ring_full = full_after_push;
			CMD_POP:  res_new.ring_full = full_q && !nonempty;
			default:  res_new.ring_full = full_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			full_q  <= 1'b0;
			bcnt_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q   <= wp_nxt;
				full_q <= (wp_nxt == rp_q);
			end else if (rd_en) begin
				rp_q   <= rp_nxt;
				full_q <= 1'b0;
			end
			if (go && is_push) begin
				bcnt_q <= last ? 2'd0 : bcnt_q + 2'd1;
			end
			if (q_rready) begin
				res_v_q <= 1'b1;
			end else if (result_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wp_q] <= wbyte;
		end
		if (rd_en) begin
			rd_q <= ring_mem[rp_q];
		end
		if (q_rready) begin
			res_q <= res_new;
		end
	end

	always_comb begin
		result         = res_q;
		result.tx_byte = res_q.tx_valid ? rd_q : CH_NUL;
	end

	assign result_valid = res_v_q;

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wp_q == rp_q))
		else $error("ring full with pointers apart");

	a_push_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q != 2'd0) |-> (q_rvalid && q_rdata.kind == CMD_PUSH))
		else $error("echo push in progress without its request at queue head");

	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(q_rready))
		else $error("result appeared without a retired request");

	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q != 2'd0) |-> (bcnt_q < q_rdata.nbytes))
		else $error("echo byte counter past request length");

endmodule

FILE: rtl/serial_line_editor_echo_ring.sv
// Top level of the serial line editor with echo and transmit ring.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      sle_pkg::in_item_t
//  result    out        result_valid / result_ready  sle_pkg::out_item_t
//
//  A request is taken every cycle while the queue has room; each gives one result.
//  Back end writes a push into the ring one echo byte at a time: 1 byte for a printable or
//  host byte, 2 for CR, 3 for backspace. Ring writes go through one memory write port.
//  Requests pass through the front stage, the queue and the result register.
//  Reset clears line store (valid bits), pointers and flags; no clearing pass.
//  Result stalls back up through the queue into the front stage and item_ready.
module serial_line_editor_echo_ring #(
	parameter int LINE_LEN   = sle_pkg::LINE_LEN_DEF,
	parameter int RING_DEPTH = sle_pkg::RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  sle_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output sle_pkg::out_item_t result
);
	import sle_pkg::*;

	logic q_wvalid;
	logic q_wready;
	cmd_t q_wdata;
	logic q_rvalid;
	logic q_rready;
	cmd_t q_rdata;

	sle_front #(
		.LINE_LEN (LINE_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_wvalid   (q_wvalid),
		.q_wready   (q_wready),
		.q_wdata    (q_wdata)
	);

	sle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wvalid (q_wvalid),
		.wready (q_wready),
		.wdata  (q_wdata),
		.rvalid (q_rvalid),
		.rready (q_rready),
		.rdata  (q_rdata)
	);

	sle_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rvalid     (q_rvalid),
		.q_rready     (q_rready),
		.q_rdata      (q_rdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: sim/testbench.sv
// Testbench for the serial line editor: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module testbench;
	import sle_pkg::*;

	localparam int LINE_LEN   = LINE_LEN_DEF;
	localparam int RING_DEPTH = RING_DEPTH_DEF;
	localparam int LPW        = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
	localparam int RPW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	// Set during the stretch where neither side pauses.
	bit no_idle = 1'b0;
	int mismatches = 0;

	// Predictor state.
	logic [7:0] line_mem [LINE_LEN];
	int         fill_pos;
	bit         line_done;
	logic [7:0] echo_ring [RING_DEPTH];
	int         ring_wr;
	int         ring_rd;
	bit         ring_is_full;

	out_item_t line_echo_results [$];

	serial_line_editor_echo_ring DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("serial_line_editor_echo_ring test failed");
		$finish;
	end

	function automatic void ring_store(logic [7:0] b);
		if (!ring_is_full) begin
			echo_ring[RPW'(ring_wr)] = b;
			ring_wr = (ring_wr + 1) % RING_DEPTH;
			if (ring_wr == ring_rd)
				ring_is_full = 1'b1;
		end
	endfunction

	function automatic out_item_t line_editor_step(in_item_t req);
		out_item_t  res;
		logic [7:0] ch;
		res = '0;
		case (req.op)
			OP_RX_BYTE: begin
				ch = req.data_byte & CH_MASK7;
				if (ch == CH_CR) begin
					if (fill_pos < LINE_LEN)
						line_mem[LPW'(fill_pos)] = CH_NUL;
					fill_pos = 0;
					ring_store(CH_CR);
					ring_store(CH_LF);
					line_done = 1'b1;
				end else if (ch == CH_BS && fill_pos > 0) begin
					fill_pos--;
					ring_store(CH_BS);
					ring_store(CH_SPACE);
					ring_store(CH_BS);
				end else if (ch >= CH_SPACE) begin
					ch = ch | CH_SPACE;
					if (fill_pos < LINE_LEN - 1) begin
						line_mem[LPW'(fill_pos)] = ch;
						fill_pos++;
						ring_store(ch);
					end
				end
			end
			OP_TX_READY: begin
				if (ring_wr != ring_rd || ring_is_full) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = echo_ring[RPW'(ring_rd)];
					ring_rd      = (ring_rd + 1) % RING_DEPTH;
					ring_is_full = 1'b0;
				end
			end
			OP_HOST_WR: begin
				ring_store(req.data_byte);
			end
			default: begin
			end
		endcase
		// line_ready reflects the flag before this request's clear
		res.line_ready = line_done;
		if (req.op == OP_LINE_RD) begin
			if (req.line_index < LINE_LEN)
				res.line_char = line_mem[LPW'(req.line_index)];
			if (req.clear_ready)
				line_done = 1'b0;
		end
		res.ring_full = ring_is_full;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (line_echo_results.size() == 0) begin
				report_mismatch("result with nothing pending", int'(result), 0);
			end else begin
				want = line_echo_results.pop_front();
				if (result.tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", int'(result.tx_valid),
						int'(want.tx_valid));
				if (result.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", int'(result.tx_byte), int'(want.tx_byte));
				if (result.line_ready !== want.line_ready)
					report_mismatch("line_ready", int'(result.line_ready),
						int'(want.line_ready));
				if (result.line_char !== want.line_char)
					report_mismatch("line_char", int'(result.line_char),
						int'(want.line_char));
				if (result.ring_full !== want.ring_full)
					report_mismatch("ring_full", int'(result.ring_full),
						int'(want.ring_full));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			result_ready <= no_idle || ($urandom_range(99) >= 21);
	end

	// Offers one request, holds it until taken, then records its prediction.
	task automatic send_item(input logic [1:0] op, input logic [7:0] data,
			input logic [4:0] idx, input logic clr);
		in_item_t req;
		req = '{op: op, data_byte: data, line_index: idx, clear_ready: clr};
		while (!no_idle && $urandom_range(99) < 21) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
		line_echo_results.push_back(line_editor_step(req));
	endtask

	// Received byte: mostly printable, some edits and line ends, some noise; bit 7 random.
	function automatic logic [7:0] typed_byte(input int cr_pct);
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(99);
		b    = 8'($urandom);
		if (pick < 12)
			b[6:0] = CH_BS[6:0];
		else if (pick < 12 + cr_pct)
			b[6:0] = CH_CR[6:0];
		else if (pick < 88)
			b[6:0] = 7'($urandom_range(7'h7E, 7'h20));
		return b;
	endfunction

	function automatic logic [4:0] line_pick();
		if ($urandom_range(99) < 85)
			return 5'($urandom_range(LINE_LEN - 1, 0));
		return 5'($urandom_range(31, LINE_LEN));
	endfunction

	task automatic random_stream(input int count, input int pop_pct, input int cr_pct);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < pop_pct)
				send_item(OP_TX_READY, 8'($urandom), 5'($urandom), 1'($urandom));
			else if (pick < pop_pct + 12)
				send_item(OP_HOST_WR, 8'($urandom), 5'($urandom), 1'($urandom));
			else if (pick < pop_pct + 30)
				send_item(OP_LINE_RD, 8'($urandom), line_pick(), 1'($urandom));
			else
				send_item(OP_RX_BYTE, typed_byte(cr_pct), 5'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_directed();
		send_item(OP_TX_READY, 8'hFF, 5'd0, 1'b1);      // pop from empty ring
		send_item(OP_LINE_RD, 8'h00, 5'd0, 1'b0);       // store is zero after reset
		send_item(OP_LINE_RD, 8'h00, 5'd31, 1'b0);      // index past the store
		send_item(OP_RX_BYTE, CH_BS, 5'd0, 1'b0);       // backspace on empty line
		send_item(OP_RX_BYTE, 8'h01, 5'd0, 1'b0);       // control byte dropped
		send_item(OP_RX_BYTE, 8'h41, 5'd31, 1'b1);      // clear bit ignored here
		send_item(OP_RX_BYTE, 8'hC2, 5'd0, 1'b0);       // bit 7 masked off
		send_item(OP_RX_BYTE, 8'h7F, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, CH_SPACE, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, 8'h00, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, CH_BS, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, 8'h88, 5'd0, 1'b0);       // masked backspace
		send_item(OP_HOST_WR, 8'hFF, 5'd0, 1'b1);
		send_item(OP_HOST_WR, 8'h00, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, 8'h8D, 5'd0, 1'b0);       // masked carriage return
		send_item(OP_LINE_RD, 8'h00, 5'd0, 1'b0);
		send_item(OP_LINE_RD, 8'h00, 5'd1, 1'b0);
		send_item(OP_LINE_RD, 8'h00, 5'd2, 1'b1);
		send_item(OP_LINE_RD, 8'hFF, 5'd19, 1'b0);
		send_item(OP_LINE_RD, 8'h00, 5'd20, 1'b1);
		repeat (6) send_item(OP_TX_READY, 8'h00, 5'd0, 1'b0);
	endtask

	// More printable bytes than the line holds; the extra ones get no echo.
	task automatic test_line_full();
		repeat (LINE_LEN + 2)
			send_item(OP_RX_BYTE, {1'($urandom), 7'($urandom_range(7'h7E, 7'h20))},
				5'($urandom), 1'($urandom));
		send_item(OP_LINE_RD, 8'h00, 5'(LINE_LEN - 2), 1'b0);
		send_item(OP_LINE_RD, 8'h00, 5'(LINE_LEN - 1), 1'b0);
		send_item(OP_RX_BYTE, CH_CR, 5'd0, 1'b0);
		send_item(OP_LINE_RD, 8'h00, 5'(LINE_LEN - 2), 1'b1);
		repeat (LINE_LEN + 4)
			send_item(OP_TX_READY, 8'($urandom), 5'($urandom), 1'($urandom));
	endtask

	// Fill the ring past full, then drain it past empty.
	task automatic test_ring_full();
		repeat (RING_DEPTH + 4)
			send_item(OP_HOST_WR, 8'($urandom), 5'($urandom), 1'($urandom));
		send_item(OP_RX_BYTE, 8'h78, 5'd0, 1'b0);
		send_item(OP_RX_BYTE, CH_BS, 5'd0, 1'b0);
		repeat (RING_DEPTH + 2)
			send_item(OP_TX_READY, 8'($urandom), 5'($urandom), 1'($urandom));
	endtask

	task automatic test_random_traffic();
		random_stream(350, 35, 7);
		random_stream(200, 6, 2);
		random_stream(300, 45, 7);
	endtask

	task automatic test_no_idle();
		no_idle = 1'b1;
		random_stream(250, 30, 4);
		no_idle = 1'b0;
		random_stream(100, 30, 5);
	endtask

	initial begin
		for (int i = 0; i < LINE_LEN; i++)
			line_mem[LPW'(i)] = 8'h00;
		fill_pos     = 0;
		line_done    = 1'b0;
		ring_wr      = 0;
		ring_rd      = 0;
		ring_is_full = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_line_full();
		test_ring_full();
		test_random_traffic();
		test_no_idle();

		item_valid <= 1'b0;
		while (line_echo_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("serial_line_editor_echo_ring test passed");
		else
			$display("serial_line_editor_echo_ring test failed");
		$finish;
	end

endmodule
